// ----- hdl/mmch_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mmch_pkg: shared types for the min merge cost heap
// Request and result structs, controller/datapath command and status.
// ----------------------------------------------------------------------------
package mmch_pkg;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } mmch_req_t;

    typedef struct packed {
        logic [63:0] total_cost;
        logic        dropped;
    } mmch_res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PUSH_WR,
        ST_UP_RD,
        ST_UP_WAIT,
        ST_UP_CMP,
        ST_CHK,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_POP_MOVE,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_WAITL,
        ST_DN_WAITR,
        ST_DN_CMP,
        ST_DN_SWAP,
        ST_MERGE_NEXT,
        ST_PUSH_SUM,
        ST_DONE
    } mmch_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_req;     // capture last flag; reset cost when last is set
        logic push_set;     // key = request value or sum
        logic push_sum;     // select sum as pushed key
        logic push_wr;      // write key at count, pos = count, count++
        logic drop;         // mark overflow
        logic up_rd;        // read parent of pos
        logic up_swap;      // write pos slot <- parent data, pos = parent
        logic pop_rd0;      // read slot 0
        logic pop_rdlast;   // count--, read slot count-1
        logic pop_move;     // top captured; key <- last, pos = 0
        logic dn_rdl;       // read left child
        logic dn_rdr;       // read right child
        logic dn_capl;      // capture left data
        logic dn_capr;      // capture right data
        logic dn_swap;      // swap pos with best child
        logic key_wr;       // write key at pos where a walk stops
        logic cap_top;      // capture popped top
        logic cap_a;        // store first popped value
        logic add_cost;     // sum = a + top; cost += sum
        logic finish;       // output result, clear heap
    } mmch_cmd_t;

    typedef struct packed {
        logic full;
        logic at_root;
        logic up_stop;
        logic cnt_gt1;
        logic cnt_zero;
        logic has_l;
        logic has_r;
        logic dn_stop;
        logic last;
    } mmch_sts_t;

endpackage

`default_nettype wire

// ----- hdl/mmch_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mmch_ram: generic single-port RAM
// One write or one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module mmch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ----- hdl/mmch_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mmch_datapath: heap storage, pointers, compare and cost accumulation
// Heap walks step one entry access per cycle through a single-port RAM.
// ----------------------------------------------------------------------------
module mmch_datapath
    import mmch_pkg::*;
#(
    parameter int HEAP_DEPTH  = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire mmch_req_t req,
    input  wire mmch_cmd_t cmd,
    output mmch_sts_t      sts,
    output mmch_res_t      res_data
);

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int KW = 64;
    localparam logic [31:0] VMASK = (VALUE_WIDTH >= 32) ? 32'hFFFF_FFFF
                                  : 32'((64'd1 << VALUE_WIDTH) - 64'd1);

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [KW-1:0] key_reg, key_next;
    logic [KW-1:0] a_reg, a_next;
    logic [KW-1:0] top_reg, top_next;
    logic [KW-1:0] lval_reg, lval_next;
    logic [KW-1:0] rval_reg, rval_next;
    logic [KW-1:0] cost_reg, cost_next;
    logic [KW-1:0] sum_reg, sum_next;
    logic          last_reg, last_next;

    logic          we;
    logic [AW-1:0] addr;
    logic [KW-1:0] wdata, rdata;

    logic [CW:0]   lidx, ridx;
    logic [AW-1:0] parent;
    logic          pick_r;
    logic [KW-1:0] best_val;
    logic [AW-1:0] best_idx;
    logic [KW-1:0] masked;

    assign masked  = {32'd0, req.value & VMASK};
    assign parent  = (pos_reg - AW'(1)) >> 1;
    assign lidx    = {pos_reg, 1'b1} + (CW+1)'(0);
    assign ridx    = lidx + (CW+1)'(1);
    assign pick_r  = (ridx < (CW+1)'(count_reg)) && (rval_reg < lval_reg);
    assign best_val = pick_r ? rval_reg : lval_reg;
    assign best_idx = pick_r ? ridx[AW-1:0] : lidx[AW-1:0];

    mmch_ram #(.WIDTH(KW), .DEPTH(HEAP_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    // status toward the controller
    always_comb
    begin
        sts.full     = (count_reg == CW'(HEAP_DEPTH));
        sts.at_root  = (pos_reg == '0);
        sts.up_stop  = (rdata < key_reg);
        sts.cnt_gt1  = (count_reg > CW'(1));
        sts.cnt_zero = (count_reg == '0);
        sts.has_l    = (lidx < (CW+1)'(count_reg));
        sts.has_r    = (ridx < (CW+1)'(count_reg));
        sts.dn_stop  = !(best_val < key_reg);
        sts.last     = last_reg;
    end

    assign res_data.total_cost = cost_reg;
    assign res_data.dropped    = ovf_reg;

    // RAM port and register updates
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        a_next     = a_reg;
        top_next   = top_reg;
        lval_next  = lval_reg;
        rval_next  = rval_reg;
        cost_next  = cost_reg;
        sum_next   = sum_reg;
        last_next  = last_reg;
        we    = 1'b0;
        addr  = pos_reg;
        wdata = key_reg;
        if (cmd.load_req)
        begin
            last_next = req.last;
        end
        if (cmd.push_set)
        begin
            key_next = cmd.push_sum ? sum_reg : masked;
        end
        if (cmd.drop)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.push_wr)
        begin
            we         = 1'b1;
            addr       = count_reg[AW-1:0];
            pos_next   = count_reg[AW-1:0];
            count_next = count_reg + CW'(1);
        end
        if (cmd.up_rd)
        begin
            addr = parent;
        end
        if (cmd.up_swap)
        begin
            // parent data already in rdata; move it down, key moves up
            we       = 1'b1;
            addr     = pos_reg;
            wdata    = rdata;
            pos_next = parent;
        end
        if (cmd.pop_rd0)
        begin
            addr = '0;
        end
        if (cmd.cap_top)
        begin
            top_next = rdata;
        end
        if (cmd.pop_rdlast)
        begin
            count_next = count_reg - CW'(1);
            addr       = AW'(count_reg - CW'(1));
        end
        if (cmd.pop_move)
        begin
            key_next = rdata;
            pos_next = '0;
        end
        if (cmd.dn_rdl)
        begin
            addr = lidx[AW-1:0];
        end
        if (cmd.dn_rdr)
        begin
            addr = ridx[AW-1:0];
        end
        if (cmd.dn_capl)
        begin
            lval_next = rdata;
        end
        if (cmd.dn_capr)
        begin
            rval_next = rdata;
        end
        if (cmd.dn_swap)
        begin
            we       = 1'b1;
            addr     = pos_reg;
            wdata    = best_val;
            pos_next = best_idx;
        end
        // key lands at its final slot when a walk stops
        if (cmd.key_wr)
        begin
            we    = 1'b1;
            addr  = pos_reg;
            wdata = key_reg;
        end
        if (cmd.cap_a)
        begin
            a_next = top_reg;
        end
        if (cmd.add_cost)
        begin
            sum_next  = a_reg + top_reg;
            cost_next = cost_reg + a_reg + top_reg;
        end
        if (cmd.load_req && req.last)
        begin
            cost_next = '0;
        end
        if (cmd.finish)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        key_reg  <= key_next;
        a_reg    <= a_next;
        top_reg  <= top_next;
        lval_reg <= lval_next;
        rval_reg <= rval_next;
        cost_reg <= cost_next;
        sum_reg  <= sum_next;
    end

endmodule

`default_nettype wire

// ----- hdl/mmch_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mmch_ctrl: sequencer for insert, sift-up, pop, sift-down and merge loop
// Key is kept in a register during walks; stops write it back to pos.
// ----------------------------------------------------------------------------
module mmch_ctrl
    import mmch_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire mmch_sts_t sts,
    output mmch_cmd_t      cmd,
    output logic           busy,
    output logic           done
);

    mmch_state_t state_reg, state_next;
    logic        second_reg, second_next;   // second pop of a merge
    logic        merging_reg, merging_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            second_reg  <= 1'b0;
            merging_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            second_reg  <= second_next;
            merging_reg <= merging_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        second_next  = second_reg;
        merging_next = merging_reg;
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    cmd.push_set = 1'b1;
                    merging_next = 1'b0;
                    state_next   = ST_PUSH_WR;
                end
            end
            ST_PUSH_WR:
            begin
                if (sts.full)
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_CHK;
                end
                else
                begin
                    cmd.push_wr = 1'b1;
                    state_next  = ST_UP_RD;
                end
            end
            ST_UP_RD:
            begin
                if (sts.at_root)
                begin
                    cmd.key_wr = 1'b1;
                    state_next = ST_CHK;
                end
                else
                begin
                    cmd.up_rd  = 1'b1;
                    state_next = ST_UP_WAIT;
                end
            end
            ST_UP_WAIT:
            begin
                // hold the parent address so its data is still out next cycle
                cmd.up_rd  = 1'b1;
                state_next = ST_UP_CMP;
            end
            ST_UP_CMP:
            begin
                // parent moves down on a swap; key is written where it stops
                if (sts.up_stop)
                begin
                    cmd.key_wr = 1'b1;
                    state_next = ST_CHK;
                end
                else
                begin
                    cmd.up_swap = 1'b1;
                    state_next  = ST_UP_RD;
                end
            end
            ST_CHK:
            begin
                if (!(merging_reg || sts.last))
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.cnt_gt1)
                begin
                    merging_next = 1'b1;
                    second_next  = 1'b0;
                    state_next   = ST_POP_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_POP_RD:
            begin
                cmd.pop_rd0 = 1'b1;
                state_next  = ST_POP_WAIT;
            end
            ST_POP_WAIT:
            begin
                cmd.cap_top    = 1'b1;
                cmd.pop_rdlast = 1'b1;
                state_next     = ST_POP_MOVE;
            end
            ST_POP_MOVE:
            begin
                cmd.pop_move = 1'b1;
                state_next   = ST_DN_RDL;
            end
            ST_DN_RDL:
            begin
                if (!sts.has_l)
                begin
                    cmd.key_wr = 1'b1;
                    state_next = ST_MERGE_NEXT;
                end
                else
                begin
                    cmd.dn_rdl = 1'b1;
                    state_next = ST_DN_RDR;
                end
            end
            ST_DN_RDR:
            begin
                // left data is out while the right read is issued
                cmd.dn_rdr  = 1'b1;
                cmd.dn_capl = 1'b1;
                state_next  = ST_DN_WAITL;
            end
            ST_DN_WAITL:
            begin
                cmd.dn_capr = 1'b1;
                state_next  = ST_DN_WAITR;
            end
            ST_DN_WAITR:
            begin
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                if (sts.dn_stop)
                begin
                    cmd.key_wr = 1'b1;
                    state_next = ST_MERGE_NEXT;
                end
                else
                begin
                    state_next = ST_DN_SWAP;
                end
            end
            ST_DN_SWAP:
            begin
                cmd.dn_swap = 1'b1;
                state_next  = ST_DN_RDL;
            end
            ST_MERGE_NEXT:
            begin
                if (!second_reg)
                begin
                    cmd.cap_a   = 1'b1;
                    second_next = 1'b1;
                    state_next  = ST_POP_RD;
                end
                else
                begin
                    cmd.add_cost = 1'b1;
                    state_next   = ST_PUSH_SUM;
                end
            end
            ST_PUSH_SUM:
            begin
                // sum goes back into the heap
                cmd.push_set = 1'b1;
                cmd.push_sum = 1'b1;
                state_next   = ST_PUSH_WR;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/min_merge_cost_heap.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// min_merge_cost_heap: optimal merge cost over a binary min-heap
// Collects values, then merges the two smallest repeatedly and sums costs.
// ----------------------------------------------------------------------------
// Usage:
//   A request (value, last) is taken when start is high and busy is low.
//   Each value is pushed into a heap of HEAP_DEPTH entries held in a
//   single-port RAM; the sift-up walks one level per pass through the
//   read, wait and compare states, and busy stays high until it stops.
//   On a request with last set, the block pops two entries, adds them to
//   the running cost and pushes the sum, until one entry is left. A pop
//   reads the top and the last entry, then walks down reading, comparing
//   and swapping; a merge round is two pops, a sum load, a push and a check.
//   The result (total_cost, dropped) then appears for one cycle with
//   result_valid high, in the cycle after the last check; the receiver
//   cannot stall, and the heap is empty afterwards.
//   A value that arrives with the heap full is lost and sets dropped.
//   Reset empties the heap and clears the drop flag; no clearing pass.
// ----------------------------------------------------------------------------
module min_merge_cost_heap
    import mmch_pkg::*;
#(
    parameter int HEAP_DEPTH  = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire mmch_req_t request,
    output logic           busy,
    output logic           result_valid,
    output mmch_res_t      result
);

    mmch_cmd_t cmd;
    mmch_sts_t sts;
    logic      done;

    mmch_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    mmch_datapath #(
        .HEAP_DEPTH  (HEAP_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (request),
        .cmd      (cmd),
        .sts      (sts),
        .res_data (result)
    );

    assign result_valid = done;

    // a result only ends a busy period
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |-> busy)
        else $error("result outside busy");
    // after a result the block is free again
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |=> !busy)
        else $error("busy after result");

endmodule

`default_nettype wire
